@@ rtl/sgr_state_transition_encoder_defines.svh @@
// Assertion macros for the SGR encoder checker.
`ifndef SGR_STATE_TRANSITION_ENCODER_DEFINES_SVH
`define SGR_STATE_TRANSITION_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgr encoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgr encoder check failed");

`endif

@@ rtl/sgr_pkg.sv @@
package sgr_pkg;

  localparam int STATE_W = 14;

  localparam logic [STATE_W-1:0] NORMAL_STATE  = 14'h0099;
  localparam logic [STATE_W-1:0] MASK_HILITE   = 14'h0F00;
  localparam logic [STATE_W-1:0] MASK_DEFCOLOR = 14'h0088;
  localparam logic [STATE_W-1:0] MASK_NOANSI   = 14'h1000;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_5    = 8'h35;
  localparam logic [7:0] CH_7    = 8'h37;

  // Segment order within a sequence.
  localparam logic [2:0] SEG_INTRO = 3'd0;
  localparam logic [2:0] SEG_RESET = 3'd1;
  localparam logic [2:0] SEG_BOLD  = 3'd2;
  localparam logic [2:0] SEG_UNDER = 3'd3;
  localparam logic [2:0] SEG_FLASH = 3'd4;
  localparam logic [2:0] SEG_INV   = 3'd5;
  localparam logic [2:0] SEG_FG    = 3'd6;
  localparam logic [2:0] SEG_BG    = 3'd7;

  typedef struct packed {
    logic       empty;
    logic [7:0] seg_en;
    logic [3:0] fg;
    logic [3:0] bg;
  } plan_t;

endpackage

@@ rtl/sgr_plan.sv @@
module sgr_plan (
  input  logic [13:0]   state_before,
  input  logic [13:0]   state_after,
  input  logic          skip_black_bg,
  output sgr_pkg::plan_t plan
);
  import sgr_pkg::*;

  logic [STATE_W-1:0] set0;
  logic [STATE_W-1:0] clr0;
  logic [STATE_W-1:0] set_bits;
  logic [STATE_W-1:0] clr_bits;
  logic [STATE_W-1:0] chg_bits;
  logic               need_reset;
  logic               fg_en;
  logic               bg_en;

  always_comb begin
    set0 = ~state_before & state_after;
    clr0 = state_before & ~state_after;
    need_reset = (|(clr0 & MASK_HILITE)) || (|(set0 & MASK_DEFCOLOR)) ||
                 (clr0 == MASK_NOANSI);
    if (need_reset) begin
      set_bits = ~NORMAL_STATE & state_after;
      clr_bits = NORMAL_STATE & ~state_after;
    end else begin
      set_bits = set0;
      clr_bits = clr0;
    end
    chg_bits = set_bits | clr_bits;
    fg_en = |chg_bits[3:0];
    bg_en = (|chg_bits[7:4]) && !(skip_black_bg && (state_after[7:4] == 4'h0));
    plan.seg_en = {bg_en, fg_en, set_bits[11:8], need_reset, 1'b1};
    plan.empty  = (state_before == state_after) || !(|plan.seg_en[7:1]);
    plan.fg     = state_after[3:0];
    plan.bg     = state_after[7:4];
  end

endmodule

@@ rtl/sgr_emit.sv @@
module sgr_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           plan_valid,
  input  sgr_pkg::plan_t plan_in,
  output logic           plan_take,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     seq_byte,
  output logic           last_byte,
  output logic           no_sequence
);
  import sgr_pkg::*;

  logic       active;
  plan_t      cur;
  logic [2:0] seg;
  logic [1:0] pos;

  logic [7:0] higher;
  logic       more;
  logic [2:0] nxt;
  logic       seg_end;
  logic       cur_last;
  logic [7:0] end_char;
  logic [7:0] byte_val;
  logic       adv;
  logic       emit;

  always_comb begin
    higher = cur.seg_en & (8'hFE << seg);
    more = |higher;
    nxt = SEG_INTRO;
    for (int i = 7; i >= 0; i--) begin
      if (higher[i]) begin
        nxt = 3'(i);
      end
    end
    seg_end = (seg[2] & seg[1]) ? (pos == 2'd2) : (pos == 2'd1);
    cur_last = cur.empty || (seg_end && !more);
    end_char = more ? CH_SEMI : CH_M;
    case (seg)
      SEG_INTRO: byte_val = pos[0] ? CH_LBR : CH_ESC;
      SEG_RESET: byte_val = (pos == 2'd0) ? CH_0 : end_char;
      SEG_BOLD:  byte_val = (pos == 2'd0) ? CH_1 : end_char;
      SEG_UNDER: byte_val = (pos == 2'd0) ? CH_4 : end_char;
      SEG_FLASH: byte_val = (pos == 2'd0) ? CH_5 : end_char;
      SEG_INV:   byte_val = (pos == 2'd0) ? CH_7 : end_char;
      SEG_FG: begin
        if (pos == 2'd0) byte_val = CH_3;
        else if (pos == 2'd1) byte_val = CH_0 | {4'h0, cur.fg};
        else byte_val = end_char;
      end
      SEG_BG: begin
        if (pos == 2'd0) byte_val = CH_4;
        else if (pos == 2'd1) byte_val = CH_0 | {4'h0, cur.bg};
        else byte_val = end_char;
      end
      default: byte_val = CH_SEMI;
    endcase
    if (cur.empty) begin
      byte_val = 8'h00;
    end
    adv = !out_valid || out_ready;
    emit = active && adv;
    plan_take = plan_valid && (!active || (emit && cur_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= active;
      end
      if (plan_take) begin
        active <= 1'b1;
      end else if (emit && cur_last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seq_byte <= byte_val;
      last_byte <= cur_last;
      no_sequence <= cur.empty;
    end
    if (plan_take) begin
      cur <= plan_in;
      seg <= SEG_INTRO;
      pos <= 2'd0;
    end else if (emit && !cur_last) begin
      if (seg_end) begin
        seg <= nxt;
        pos <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

endmodule

@@ rtl/sgr_state_transition_encoder.sv @@
// Turns a pair of packed text-attribute states into the ANSI SGR escape
// sequence that moves a terminal from the first to the second, one byte per
// output transfer, with last_byte on the final byte and no_sequence on the
// single result of an empty transition. A sequence has 1 to 18 bytes, and the
// output register sends one byte per cycle while out_ready does not stall it;
// the next item is decoded into a plan register while the current one is still
// being sent, so items can follow with no gap.
module sgr_state_transition_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] state_before,
  input  logic [13:0] state_after,
  input  logic        skip_black_bg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  seq_byte,
  output logic        last_byte,
  output logic        no_sequence
);
  import sgr_pkg::*;

  plan_t plan_d;
  plan_t plan_q;
  logic  plan_valid;
  logic  plan_take;

  sgr_plan u_plan (
    .state_before  (state_before),
    .state_after   (state_after),
    .skip_black_bg (skip_black_bg),
    .plan          (plan_d)
  );

  assign in_ready = !plan_valid || plan_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      plan_valid <= 1'b1;
    end else if (plan_take) begin
      plan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      plan_q <= plan_d;
    end
  end

  sgr_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .plan_valid  (plan_valid),
    .plan_in     (plan_q),
    .plan_take   (plan_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seq_byte    (seq_byte),
    .last_byte   (last_byte),
    .no_sequence (no_sequence)
  );

endmodule

@@ rtl/sgr_checker.sv @@
`include "sgr_state_transition_encoder_defines.svh"

module sgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  seq_byte,
  input logic        last_byte,
  input logic        no_sequence
);
  import sgr_pkg::*;

  logic [9:0] out_word;

  assign out_word = {seq_byte, last_byte, no_sequence};

  `SGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `SGR_ASSERT_SAME(a_empty_single, out_valid && no_sequence, last_byte && (seq_byte == 8'h00))
  `SGR_ASSERT_SAME(a_final_m, out_valid && last_byte && !no_sequence, seq_byte == CH_M)
  `SGR_ASSERT_SAME(a_idle_after_reset, $past(rst), !out_valid && in_ready)

endmodule

bind sgr_state_transition_encoder sgr_checker u_sgr_checker (.*);

@@ verif/tb_top.sv @@
module tb_top;
  import sgr_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 95;

  localparam int BOLD_BIT = 8;
  localparam int UNDER_BIT = 9;
  localparam int FLASH_BIT = 10;
  localparam int INV_BIT = 11;
  localparam logic [STATE_W-1:0] FG_MASK = 14'h000F;
  localparam logic [STATE_W-1:0] BG_MASK = 14'h00F0;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } sgr_out_t;

  typedef enum {ROW_MODEL, ROW_EMPTY, ROW_TEXT} row_kind_t;

  typedef struct {
    logic [STATE_W-1:0] before_st;
    logic [STATE_W-1:0] after_st;
    logic               skip;
    row_kind_t          kind;
    string              text;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [STATE_W-1:0] state_before = '0;
  logic [STATE_W-1:0] state_after = '0;
  logic skip_black_bg = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] seq_byte;
  logic last_byte;
  logic no_sequence;

  sgr_out_t sgr_expect_q[$];
  dir_row_t dir_rows[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  sgr_state_transition_encoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .state_before(state_before),
    .state_after(state_after),
    .skip_black_bg(skip_black_bg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .seq_byte(seq_byte),
    .last_byte(last_byte),
    .no_sequence(no_sequence)
  );

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void push_empty_seq();
    sgr_out_t r;
    r.ch = 8'h00;
    r.last = 1'b1;
    r.empty = 1'b1;
    sgr_expect_q.push_back(r);
  endfunction

  function automatic void push_text_seq(input string txt);
    sgr_out_t r;
    for (int i = 0; i < txt.len(); i++) begin
      r.ch = txt[i];
      r.last = (i == txt.len() - 1);
      r.empty = 1'b0;
      sgr_expect_q.push_back(r);
    end
  endfunction

  function automatic void predict_sgr(input logic [STATE_W-1:0] b, input logic [STATE_W-1:0] a,
                                      input logic s);
    logic [7:0] chars[$];
    logic [STATE_W-1:0] setb;
    logic [STATE_W-1:0] clrb;
    logic [3:0] bg;
    sgr_out_t r;
    chars = {};
    if (b != a) begin
      chars.push_back(CH_ESC);
      chars.push_back(CH_LBR);
      setb = ~b & a;
      clrb = b & ~a;
      if ((clrb & MASK_HILITE) != 0 || (setb & MASK_DEFCOLOR) != 0 || clrb == MASK_NOANSI) begin
        chars.push_back(CH_0);
        chars.push_back(CH_SEMI);
        setb = ~NORMAL_STATE & a;
        clrb = NORMAL_STATE & ~a;
      end
      if (setb[BOLD_BIT]) begin
        chars.push_back(CH_1);
        chars.push_back(CH_SEMI);
      end
      if (setb[UNDER_BIT]) begin
        chars.push_back(CH_4);
        chars.push_back(CH_SEMI);
      end
      if (setb[FLASH_BIT]) begin
        chars.push_back(CH_5);
        chars.push_back(CH_SEMI);
      end
      if (setb[INV_BIT]) begin
        chars.push_back(CH_7);
        chars.push_back(CH_SEMI);
      end
      if (((setb | clrb) & FG_MASK) != 0) begin
        chars.push_back(CH_3);
        chars.push_back(CH_0 | {4'h0, a[3:0]});
        chars.push_back(CH_SEMI);
      end
      if (((setb | clrb) & BG_MASK) != 0) begin
        bg = a[7:4];
        if (!(s && bg == 4'h0)) begin
          chars.push_back(CH_4);
          chars.push_back(CH_0 | {4'h0, bg});
          chars.push_back(CH_SEMI);
        end
      end
      if (chars.size() > 2) chars[chars.size() - 1] = CH_M;
      else chars = {};
    end
    if (chars.size() == 0) begin
      push_empty_seq();
    end else begin
      foreach (chars[i]) begin
        r.ch = chars[i];
        r.last = (i == chars.size() - 1);
        r.empty = 1'b0;
        sgr_expect_q.push_back(r);
      end
    end
  endfunction

  task automatic send_transition(input logic [STATE_W-1:0] b, input logic [STATE_W-1:0] a,
                                 input logic s);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    state_before <= b;
    state_after <= a;
    skip_black_bg <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    sgr_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (sgr_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, byte %02h", seq_byte));
      end else begin
        want = sgr_expect_q.pop_front();
        if (no_sequence !== want.empty)
          report_mismatch($sformatf("no_sequence %b, expected %b", no_sequence, want.empty));
        if (last_byte !== want.last)
          report_mismatch($sformatf("last_byte %b, expected %b", last_byte, want.last));
        if (!want.empty && seq_byte !== want.ch)
          report_mismatch($sformatf("seq_byte %02h, expected %02h", seq_byte, want.ch));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [STATE_W-1:0] b;
    logic [STATE_W-1:0] a;
    logic s;
    int mode;
    int src_pct[4];
    int snk_pct[4];
    src_pct = '{0, 69, 0, 33};
    snk_pct = '{0, 0, 69, 33};

    dir_rows.push_back('{14'h0000, 14'h0000, 1'b0, ROW_EMPTY, ""});
    dir_rows.push_back('{14'h3FFF, 14'h3FFF, 1'b1, ROW_EMPTY, ""});
    dir_rows.push_back('{14'h0099, 14'h2099, 1'b0, ROW_EMPTY, ""});
    dir_rows.push_back('{14'h2000, 14'h0000, 1'b0, ROW_EMPTY, ""});
    dir_rows.push_back('{14'h0000, 14'h1000, 1'b0, ROW_EMPTY, ""});
    dir_rows.push_back('{14'h0090, 14'h0000, 1'b1, ROW_EMPTY, ""});
    dir_rows.push_back('{14'h0099, 14'h0000, 1'b1, ROW_TEXT, "\033[30m"});
    dir_rows.push_back('{14'h0099, 14'h0000, 1'b0, ROW_TEXT, "\033[30;40m"});
    dir_rows.push_back('{14'h1000, 14'h0000, 1'b0, ROW_TEXT, "\033[0;30;40m"});
    dir_rows.push_back('{14'h1000, 14'h0000, 1'b1, ROW_TEXT, "\033[0;30m"});
    dir_rows.push_back('{14'h0000, 14'h0099, 1'b0, ROW_TEXT, "\033[0m"});
    dir_rows.push_back('{14'h0000, 14'h0F00, 1'b0, ROW_TEXT, "\033[1;4;5;7m"});
    dir_rows.push_back('{14'h0F00, 14'h0000, 1'b0, ROW_TEXT, "\033[0;30;40m"});
    dir_rows.push_back('{14'h0000, 14'h0F88, 1'b0, ROW_MODEL, ""});
    dir_rows.push_back('{14'h0000, 14'h00FF, 1'b0, ROW_MODEL, ""});
    dir_rows.push_back('{14'h00FF, 14'h0000, 1'b1, ROW_MODEL, ""});
    dir_rows.push_back('{14'h3FFF, 14'h0000, 1'b0, ROW_MODEL, ""});
    dir_rows.push_back('{14'h0000, 14'h3FFF, 1'b1, ROW_MODEL, ""});
    dir_rows.push_back('{14'h0011, 14'h0022, 1'b0, ROW_MODEL, ""});
    dir_rows.push_back('{14'h0123, 14'h0456, 1'b1, ROW_MODEL, ""});
    dir_rows.push_back('{14'h1100, 14'h0000, 1'b0, ROW_MODEL, ""});
    dir_rows.push_back('{14'h1000, 14'h2000, 1'b0, ROW_MODEL, ""});
    dir_rows.push_back('{14'h1000, 14'h1099, 1'b1, ROW_MODEL, ""});

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_transition(dir_rows[i].before_st, dir_rows[i].after_st, dir_rows[i].skip);
      case (dir_rows[i].kind)
        ROW_EMPTY: push_empty_seq();
        ROW_TEXT: push_text_seq(dir_rows[i].text);
        default: predict_sgr(dir_rows[i].before_st, dir_rows[i].after_st, dir_rows[i].skip);
      endcase
    end

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_pct[ph];
      snk_stall_pct = snk_pct[ph];
      repeat (PHASE_ITEMS) begin
        b = STATE_W'($urandom);
        mode = $urandom_range(9);
        if (mode == 0) begin
          a = b;
        end else if (mode <= 5) begin
          a = b ^ STATE_W'(1 << $urandom_range(STATE_W - 1));
          if ($urandom_range(1) == 1) a = a ^ STATE_W'(1 << $urandom_range(STATE_W - 1));
        end else begin
          a = STATE_W'($urandom);
        end
        if ($urandom_range(9) == 0) a[7:4] = 4'h0;
        s = 1'($urandom_range(1));
        send_transition(b, a, s);
        predict_sgr(b, a, s);
      end
    end
    in_valid <= 1'b0;

    while (sgr_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sgr_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected transfers never arrived", sgr_expect_q.size()));
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
